>>> hw/rtl/ece_pkg.sv
package ece_pkg;

   // Progress and factor both carry FRAC_BITS fraction bits; 1.0 needs one more bit
   localparam int FRAC_BITS = 16;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int FACTOR_W  = 18;
   localparam int SIN_SHIFT = 30 - FRAC_BITS;

   localparam logic [T_W-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [T_W-1:0] HALF_FX = {2'b01, {(FRAC_BITS-1){1'b0}}};

   typedef longint unsigned u64_type;

   localparam u64_type HALF_PI_Q30 = 64'd1686629713;
   localparam longint  C2_Q30      = 64'sd1916082568;

   // (c2 + 1) in Q2.30 and c2 rounded to FRAC_BITS fraction bits
   localparam logic signed [32:0] C2P1_Q30 = 33'(C2_Q30 + (64'sd1 <<< 30));
   localparam logic signed [FACTOR_W-1:0] C2_FX =
      FACTOR_W'((C2_Q30 + (64'sd1 <<< (SIN_SHIFT - 1))) >>> SIN_SHIFT);

   localparam logic [3:0] FUNC_LINEAR      = 4'd0;
   localparam logic [3:0] FUNC_IN          = 4'd1;
   localparam logic [3:0] FUNC_IN_SINE     = 4'd2;
   localparam logic [3:0] FUNC_OUT         = 4'd3;
   localparam logic [3:0] FUNC_OUT_SINE    = 4'd4;
   localparam logic [3:0] FUNC_IN_OUT      = 4'd5;
   localparam logic [3:0] FUNC_IN_OUT_BACK = 4'd6;
   localparam logic [3:0] FUNC_SPIKE       = 4'd7;

   typedef struct packed {
      logic [T_W-1:0]      base;
      logic signed [T_W:0] diff;
   } sine_pair_type;

endpackage

>>> hw/rtl/ece_sine_lut.sv
module ece_sine_lut
   import ece_pkg::*;
#(
   parameter int ENTRIES = 256,
   parameter int IDX_W   = $clog2(ENTRIES + 1)
) (
   input  logic [IDX_W-1:0] idx,
   output sine_pair_type    pair
);

   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES);

   logic [T_W-1:0] tab [ENTRIES+1];
   logic [T_W-1:0] lo_w;
   logic [T_W-1:0] hi_w;

   // Quarter-wave points sin(pi/2 * i/N), Q30 Taylor series, built at elaboration
   for (genvar gi = 0; gi <= ENTRIES; gi++) begin : g_tab
      localparam u64_type X  = (HALF_PI_Q30 * u64_type'(gi) + ENTRIES / 2) / ENTRIES;
      localparam u64_type X2 = (X * X) >> 30;
      localparam u64_type T1 = ((X  * X2) >> 30) / 6;
      localparam u64_type T2 = ((T1 * X2) >> 30) / 20;
      localparam u64_type T3 = ((T2 * X2) >> 30) / 42;
      localparam u64_type T4 = ((T3 * X2) >> 30) / 72;
      localparam u64_type T5 = ((T4 * X2) >> 30) / 110;
      localparam u64_type T6 = ((T5 * X2) >> 30) / 156;
      localparam u64_type T7 = ((T6 * X2) >> 30) / 210;
      localparam u64_type T8 = ((T7 * X2) >> 30) / 272;
      localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                             + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                             + longint'(T8);
      localparam longint CLP = (SUM < 0) ? 64'sd0 :
                               ((SUM > (64'sd1 <<< 30)) ? (64'sd1 <<< 30) : SUM);
      localparam longint VAL = (CLP + (64'sd1 <<< (SIN_SHIFT - 1))) >>> SIN_SHIFT;
      assign tab[gi] = T_W'(VAL);
   end

   // At the last point there is no upper neighbor: hold the slope at zero
   always_comb begin
      lo_w = tab[idx];
      hi_w = lo_w;
      if (idx != LAST) begin
         hi_w = tab[idx + 1'b1];
      end
   end

   assign pair.base = lo_w;
   assign pair.diff = signed'({1'b0, hi_w}) - signed'({1'b0, lo_w});

endmodule

>>> hw/rtl/easing_curve_evaluator_core.sv
// Pipeline: three datapath stages plus the output register. Throughput: one item per
// cycle unless rsp_tready is low; each stage holds one item and moves on when the
// stage after it is empty or moving, so bubbles close up on a stall.
// The sine table is a constant; no clearing pass is needed.
// Reset: synchronous, clears every stage valid flag; data registers are not reset.
module easing_curve_evaluator_core
   import ece_pkg::*;
#(
   parameter int SINE_TABLE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [16:0] progress, [23:17] zero
   input  logic [3:0]  req_tuser,   // [3:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [17:0] factor, [23:18] zero
);

   localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int POS_W = T_W + IDX_W;
   localparam int KP_W  = 33 + T_W + 1;
   localparam int K_W   = KP_W - 30;
   localparam int IN_W  = K_W + 1;
   localparam int SP_W  = T_W + 1 + FRAC_BITS + 1;
   localparam int LP_W  = 2 * (T_W + 1);
   localparam int BP_W  = T_W + 1 + IN_W;
   localparam int R_W   = FACTOR_W + 6;

   localparam logic [2*T_W-1:0] SQ_RND = (2*T_W)'(1) << (FRAC_BITS - 1);
   localparam logic signed [R_W-1:0] SAT_MAX = R_W'(2**(FACTOR_W-1) - 1);
   localparam logic signed [R_W-1:0] SAT_MIN = -SAT_MAX - R_W'(1);
   localparam logic signed [R_W-1:0] ONE_R   = R_W'(signed'({1'b0, ONE_FX}));

   // Round to nearest, ties away from zero
   function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int sh);
      logic [63:0] mag;
      logic [63:0] rnd;
      mag = v[63] ? 64'(-v) : 64'(v);
      rnd = (mag + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -signed'(rnd) : signed'(rnd);
   endfunction

   logic en1, en2, en3, en4;

   // ---------------- stage 1: clamp, operand select, table position
   logic [T_W-1:0]        prog_w;
   logic [T_W-1:0]        t_in, u_in, opa_in, w_w, v_w, abs_s_w;
   logic signed [T_W:0]   s_in;
   logic                  lo_in;
   logic [POS_W-1:0]      pos_w;
   logic [IDX_W-1:0]      idx_in;
   logic [FRAC_BITS-1:0]  fr_in;

   logic                  v1_ff;
   logic [3:0]            func1_ff;
   logic [T_W-1:0]        t1_ff, opa1_ff, opb1_ff;
   logic signed [T_W:0]   s1_ff;
   logic                  lo1_ff;
   logic [IDX_W-1:0]      idx1_ff;
   logic [FRAC_BITS-1:0]  fr1_ff;

   always_comb begin
      prog_w  = req_tdata[T_W-1:0];
      t_in    = (prog_w > ONE_FX) ? ONE_FX : prog_w;
      u_in    = ONE_FX - t_in;
      lo_in   = (t_in < HALF_FX);
      v_w     = (t_in <= HALF_FX) ? {t_in[T_W-2:0], 1'b0} : {u_in[T_W-2:0], 1'b0};
      abs_s_w = lo_in ? {t_in[T_W-2:0], 1'b0} : {u_in[T_W-2:0], 1'b0};
      s_in    = lo_in ? signed'({1'b0, abs_s_w}) : -signed'({1'b0, abs_s_w});
      case (req_tuser)
         FUNC_SPIKE:       opa_in = v_w;
         FUNC_IN_OUT_BACK: opa_in = abs_s_w;
         default:          opa_in = t_in;
      endcase
      w_w    = (req_tuser == FUNC_IN_SINE) ? u_in : t_in;
      pos_w  = POS_W'(w_w) * POS_W'(SINE_TABLE_ENTRIES);
      idx_in = pos_w[FRAC_BITS +: IDX_W];
      fr_in  = pos_w[FRAC_BITS-1:0];
   end

   // ---------------- stage 2: squares, table read, (c2+1)*s
   logic [2*T_W-1:0]      sqa_p, sqb_p, sqa_r, sqb_r;
   logic [T_W-1:0]        sqa_in, sqb_in;
   logic signed [KP_W-1:0] kp_w;
   logic signed [K_W-1:0] k_in;
   sine_pair_type         pair_in;

   logic                  v2_ff;
   logic [3:0]            func2_ff;
   logic [T_W-1:0]        t2_ff, sqa2_ff, sqb2_ff;
   logic                  lo2_ff;
   sine_pair_type         pair2_ff;
   logic [FRAC_BITS-1:0]  fr2_ff;
   logic signed [K_W-1:0] k2_ff;

   ece_sine_lut #(
      .ENTRIES (SINE_TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_sine_lut (
      .idx  (idx1_ff),
      .pair (pair_in)
   );

   always_comb begin
      sqa_p  = {{T_W{1'b0}}, opa1_ff} * {{T_W{1'b0}}, opa1_ff};
      sqb_p  = {{T_W{1'b0}}, opb1_ff} * {{T_W{1'b0}}, opb1_ff};
      sqa_r  = sqa_p + SQ_RND;
      sqb_r  = sqb_p + SQ_RND;
      sqa_in = sqa_r[FRAC_BITS +: T_W];
      sqb_in = sqb_r[FRAC_BITS +: T_W];
      kp_w   = KP_W'(C2P1_Q30) * KP_W'(s1_ff);
      k_in   = K_W'(rshr(64'(kp_w), 30));
   end

   // ---------------- stage 3: interpolation, lerp and back-curve products
   logic signed [SP_W-1:0] sp_w;
   logic signed [T_W:0]    d_w;
   logic signed [LP_W-1:0] lp_w;
   logic signed [IN_W-1:0] inner_w;
   logic signed [BP_W-1:0] bp_w;
   logic signed [R_W-1:0]  sin_in, lerp_in, back_in;

   logic                   v3_ff;
   logic [3:0]             func3_ff;
   logic [T_W-1:0]         t3_ff, sqa3_ff, sqb3_ff;
   logic                   lo3_ff;
   logic signed [R_W-1:0]  sin3_ff, lerp3_ff, back3_ff;

   always_comb begin
      sp_w    = SP_W'(pair2_ff.diff) * SP_W'(signed'({1'b0, fr2_ff}));
      sin_in  = R_W'(signed'({1'b0, pair2_ff.base})) + R_W'(rshr(64'(sp_w), FRAC_BITS));
      d_w     = signed'({1'b0, ONE_FX - sqb2_ff}) - signed'({1'b0, sqa2_ff});
      lp_w    = LP_W'(d_w) * LP_W'(signed'({1'b0, t2_ff}));
      lerp_in = R_W'(rshr(64'(lp_w), FRAC_BITS));
      inner_w = lo2_ff ? (IN_W'(k2_ff) - IN_W'(C2_FX)) : (IN_W'(k2_ff) + IN_W'(C2_FX));
      bp_w    = BP_W'(signed'({1'b0, sqa2_ff})) * BP_W'(inner_w);
      // halving of the back curve folds into this shift
      back_in = R_W'(rshr(64'(bp_w), FRAC_BITS + 1));
   end

   // ---------------- stage 4: curve select and saturation
   logic signed [R_W-1:0]      r_w;
   logic [FACTOR_W-1:0]        factor_in;
   logic                       out_v_ff;
   logic [FACTOR_W-1:0]        factor_ff;

   always_comb begin
      case (func3_ff)
         FUNC_IN:          r_w = R_W'(signed'({1'b0, sqa3_ff}));
         FUNC_IN_SINE:     r_w = ONE_R - sin3_ff;
         FUNC_OUT:         r_w = ONE_R - R_W'(signed'({1'b0, sqb3_ff}));
         FUNC_OUT_SINE:    r_w = sin3_ff;
         FUNC_IN_OUT:      r_w = R_W'(signed'({1'b0, sqa3_ff})) + lerp3_ff;
         FUNC_IN_OUT_BACK: r_w = lo3_ff ? back3_ff : (back3_ff + ONE_R);
         FUNC_SPIKE:       r_w = R_W'(signed'({1'b0, sqa3_ff}));
         default:          r_w = R_W'(signed'({1'b0, t3_ff}));
      endcase
      if (r_w > SAT_MAX) begin
         factor_in = FACTOR_W'(SAT_MAX);
      end else if (r_w < SAT_MIN) begin
         factor_in = FACTOR_W'(SAT_MIN);
      end else begin
         factor_in = r_w[FACTOR_W-1:0];
      end
   end

   // ---------------- flow control: a stage advances when empty or when the next one does
   assign en4 = !out_v_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1) v1_ff    <= req_tvalid;
         if (en2) v2_ff    <= v1_ff;
         if (en3) v3_ff    <= v2_ff;
         if (en4) out_v_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         func1_ff <= req_tuser;
         t1_ff    <= t_in;
         opa1_ff  <= opa_in;
         opb1_ff  <= u_in;
         s1_ff    <= s_in;
         lo1_ff   <= lo_in;
         idx1_ff  <= idx_in;
         fr1_ff   <= fr_in;
      end
      if (en2) begin
         func2_ff <= func1_ff;
         t2_ff    <= t1_ff;
         lo2_ff   <= lo1_ff;
         sqa2_ff  <= sqa_in;
         sqb2_ff  <= sqb_in;
         pair2_ff <= pair_in;
         fr2_ff   <= fr1_ff;
         k2_ff    <= k_in;
      end
      if (en3) begin
         func3_ff <= func2_ff;
         t3_ff    <= t2_ff;
         lo3_ff   <= lo2_ff;
         sqa3_ff  <= sqa2_ff;
         sqb3_ff  <= sqb2_ff;
         sin3_ff  <= sin_in;
         lerp3_ff <= lerp_in;
         back3_ff <= back_in;
      end
      if (en4) begin
         factor_ff <= factor_in;
      end
   end

   assign req_tready = en1;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(24-FACTOR_W){1'b0}}, factor_ff};

endmodule
